// ----- sv/lsdc_pkg.sv -----
// Package for the lunar/solar date converter: year table, calendar tables, helpers.
// No dependencies.
package lsdc_pkg;

    localparam int unsigned FIRST_YEAR_C = 1901;
    localparam int unsigned LAST_YEAR_C  = 2099;
    localparam int unsigned YEAR_NUM     = 199;

    localparam logic KIND_G2L = 1'b0;
    localparam logic KIND_L2G = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        leap_flag;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [11:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic        out_leap;
    } t_rsp;

    function automatic logic [23:0] year_word(input logic [7:0] idx);
        logic [23:0] t [0:YEAR_NUM-1];
        t = '{
        24'h04AE53,24'h0A5748,24'h5526BD,24'h0D2650,24'h0D9544,24'h46AAB9,24'h056A4D,24'h09AD42,
        24'h24AEB6,24'h04AE4A,24'h6A4DBE,24'h0A4D52,24'h0D2546,24'h5D52BA,24'h0B544E,24'h0D6A43,
        24'h296D37,24'h095B4B,24'h749BC1,24'h049754,24'h0A4B48,24'h5B25BC,24'h06A550,24'h06D445,
        24'h4ADAB8,24'h02B64D,24'h095742,24'h2497B7,24'h04974A,24'h664B3E,24'h0D4A51,24'h0EA546,
        24'h56D4BA,24'h05AD4E,24'h02B644,24'h393738,24'h092E4B,24'h7C96BF,24'h0C9553,24'h0D4A48,
        24'h6DA53B,24'h0B554F,24'h056A45,24'h4AADB9,24'h025D4D,24'h092D42,24'h2C95B6,24'h0A954A,
        24'h7B4ABD,24'h06CA51,24'h0B5546,24'h555ABB,24'h04DA4E,24'h0A5B43,24'h352BB8,24'h052B4C,
        24'h8A953F,24'h0E9552,24'h06AA48,24'h6AD53C,24'h0AB54F,24'h04B645,24'h4A5739,24'h0A574D,
        24'h052642,24'h3E9335,24'h0D9549,24'h75AABE,24'h056A51,24'h096D46,24'h54AEBB,24'h04AD4F,
        24'h0A4D43,24'h4D26B7,24'h0D254B,24'h8D52BF,24'h0B5452,24'h0B6A47,24'h696D3C,24'h095B50,
        24'h049B45,24'h4A4BB9,24'h0A4B4D,24'hAB25C2,24'h06A554,24'h06D449,24'h6ADA3D,24'h0AB651,
        24'h093746,24'h5497BB,24'h04974F,24'h064B44,24'h36A537,24'h0EA54A,24'h86B2BF,24'h05AC53,
        24'h0AB647,24'h5936BC,24'h092E50,24'h0C9645,24'h4D4AB8,24'h0D4A4C,24'h0DA541,24'h25AAB6,
        24'h056A49,24'h7AADBD,24'h025D52,24'h092D47,24'h5C95BA,24'h0A954E,24'h0B4A43,24'h4B5537,
        24'h0AD54A,24'h955ABF,24'h04BA53,24'h0A5B48,24'h652BBC,24'h052B50,24'h0A9345,24'h474AB9,
        24'h06AA4C,24'h0AD541,24'h24DAB6,24'h04B64A,24'h69573D,24'h0A4E51,24'h0D2646,24'h5E933A,
        24'h0D534D,24'h05AA43,24'h36B537,24'h096D4B,24'hB4AEBF,24'h04AD53,24'h0A4D48,24'h6D25BC,
        24'h0D254F,24'h0D5244,24'h5DAA38,24'h0B5A4C,24'h056D41,24'h24ADB6,24'h049B4A,24'h7A4BBE,
        24'h0A4B51,24'h0AA546,24'h5B52BA,24'h06D24E,24'h0ADA42,24'h355B37,24'h09374B,24'h8497C1,
        24'h049753,24'h064B48,24'h66A53C,24'h0EA54F,24'h06B244,24'h4AB638,24'h0AAE4C,24'h092E42,
        24'h3C9735,24'h0C9649,24'h7D4ABD,24'h0D4A51,24'h0DA545,24'h55AABA,24'h056A4E,24'h0A6D43,
        24'h452EB7,24'h052D4B,24'h8A95BF,24'h0A9553,24'h0B4A47,24'h6B553B,24'h0AD54F,24'h055A45,
        24'h4A5D38,24'h0A5B4C,24'h052B42,24'h3A93B6,24'h069349,24'h7729BD,24'h06AA51,24'h0AD546,
        24'h54DABA,24'h04B64E,24'h0A5743,24'h452738,24'h0D264A,24'h8E933E,24'h0D5252,24'h0DAA47,
        24'h66B53B,24'h056D4F,24'h04AE45,24'h4A4EB9,24'h0A4D4C,24'h0D1541,24'h2D92B5};
        if (idx < 8'(YEAR_NUM)) begin
            return t[idx];
        end
        return 24'h0;
    endfunction

    // Days before the start of a Gregorian month (index 0 to 12).
    function automatic logic [8:0] cum_days(input logic [3:0] m, input logic lp);
        logic [8:0] c;
        case (m)
            4'd0:  c = 9'd0;
            4'd1:  c = 9'd31;
            4'd2:  c = 9'd59;
            4'd3:  c = 9'd90;
            4'd4:  c = 9'd120;
            4'd5:  c = 9'd151;
            4'd6:  c = 9'd181;
            4'd7:  c = 9'd212;
            4'd8:  c = 9'd243;
            4'd9:  c = 9'd273;
            4'd10: c = 9'd304;
            4'd11: c = 9'd334;
            default: c = 9'd365;
        endcase
        if (lp && m >= 4'd2) begin
            c = c + 9'd1;
        end
        return c;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
        logic [4:0] r;
        case (m)
            4'd2:                      r = lp ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
            default:                   r = 5'd31;
        endcase
        return r;
    endfunction

    // Within 1900..2100 only 1900 and 2100 are the century exceptions.
    function automatic logic greg_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != 12'd1900) && (y != 12'd2100);
    endfunction

    function automatic logic [4:0] slot_len(input logic [23:0] w, input logic [3:0] m);
        logic [4:0] r;
        r = 5'd29;
        if (m >= 4'd1 && m <= 4'd13) begin
            r = w[5'd20 - {1'b0, m}] ? 5'd30 : 5'd29;
        end
        return r;
    endfunction

    function automatic logic [8:0] spring_off(input logic [23:0] w);
        return {4'd0, w[4:0]} - 9'd1 + ((w[6:5] == 2'd2) ? 9'd31 : 9'd0);
    endfunction

endpackage

// ----- sv/lsdc_if.sv -----
// Valid/ready channel carrying one payload of type T.
// Depends on nothing; payload types come from lsdc_pkg.
interface lsdc_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/lunar_solar_date_converter.sv -----
// Lunar/Gregorian date converter, 1901 to 2099.
// Accepts one item per cycle while the output is not stalled.
// Stages: table fetch, then 14 month-walk stages, then a year-rollover stage and
// an output register that names the month. The whole pipeline advances when the
// output is free; stalls hold every stage. Synchronous active-low reset clears valids.
module lunar_solar_date_converter
    import lsdc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lsdc_if.sink   i_req,
    lsdc_if.source o_rsp
);

    localparam int NST = 16;

    // Work record carried along the pipe.
    typedef struct packed {
        logic        bad;
        logic        kind;
        logic [11:0] year;
        logic [23:0] w;     // word of current year
        logic [23:0] pw;    // word of previous year
        logic [3:0]  slot;  // lunar slot (walk target / counter)
        logic [8:0]  pos;   // running day count
        logic [8:0]  rem;
        logic        back;  // g2l backward walk from next new year
        logic        done;
        logic [4:0]  len;
        logic [4:0]  day;
    } t_work;

    logic  [NST-1:0] r_vld;
    t_work           r_st [NST];
    t_work           n_st [NST];
    t_rsp            r_out;
    logic            r_out_vld;
    logic            adv;

    assign adv       = !r_out_vld || o_rsp.ready;
    assign i_req.ready = adv;
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    // Stage 0: validate the request and fetch the table words.
    always_comb begin
        t_req        q;
        logic [23:0] w;
        logic [3:0]  lm;
        logic [3:0]  sl;
        logic [8:0]  doy;
        logic [8:0]  sp;
        logic        lp;
        q = i_req.data;
        n_st[0] = '0;
        sl  = 4'd0;
        doy = 9'd0;
        w  = year_word(8'(q.year - 12'(FIRST_YEAR_C)));
        lm = w[23:20];
        lp = greg_leap(q.year);
        sp = spring_off(w);
        n_st[0].kind = q.kind;
        n_st[0].year = q.year;
        n_st[0].w    = w;
        n_st[0].pw   = year_word(8'(q.year - 12'(FIRST_YEAR_C) - 12'd1));
        n_st[0].day  = q.day;
        n_st[0].bad  = !(q.year >= 12'(FIRST_YEAR_C) && q.year <= 12'(LAST_YEAR_C)
                         && q.month >= 4'd1 && q.month <= 4'd12 && q.day != 5'd0);
        if (q.kind == KIND_L2G) begin
            sl = q.month;
            if (lm != 4'd0 && (q.month > lm || (q.month == lm && q.leap_flag))) begin
                sl = q.month + 4'd1;
            end
            n_st[0].slot = sl;
            if (q.day > slot_len(w, sl)) begin
                n_st[0].bad = 1'b1;
            end
            n_st[0].pos = sp;
            // rem counts slots still to add.
            n_st[0].rem = {5'd0, sl - 4'd1};
        end else begin
            if (q.day > month_len(q.month, lp)) begin
                n_st[0].bad = 1'b1;
            end
            doy = cum_days(q.month - 4'd1, lp) + {4'd0, q.day} - 9'd1;
            if (doy >= sp) begin
                n_st[0].rem  = doy - sp;
                n_st[0].slot = 4'd1;
            end else begin
                if (q.year == 12'(FIRST_YEAR_C)) begin
                    n_st[0].bad = 1'b1;
                end
                n_st[0].back = 1'b1;
                n_st[0].rem  = sp - doy;
                n_st[0].w    = n_st[0].pw;
                n_st[0].year = q.year - 12'd1;
                n_st[0].slot = (n_st[0].pw[23:20] != 4'd0) ? 4'd13 : 4'd12;
                n_st[0].len  = slot_len(n_st[0].pw, n_st[0].slot);
            end
        end
    end

    // Stages 1 to 14: one month step each.
    for (genvar g = 1; g < NST - 1; g++) begin : g_walk
        always_comb begin
            t_work s;
            logic [4:0] ln;
            s  = r_st[g-1];
            ln = slot_len(s.w, s.slot);
            if (s.kind == KIND_L2G) begin
                if (s.rem != 9'd0) begin
                    s.pos = s.pos + 9'(slot_len(s.w, 4'(s.slot - 4'(s.rem))));
                    s.rem = s.rem - 9'd1;
                end
            end else if (!s.done) begin
                if (!s.back) begin
                    if (s.rem >= {4'd0, ln}) begin
                        s.rem  = s.rem - {4'd0, ln};
                        s.slot = s.slot + 4'd1;
                    end else begin
                        s.done = 1'b1;
                    end
                end else if (g <= 3 && s.slot > 4'd10) begin
                    s.len = ln;
                    if (s.rem > {4'd0, ln}) begin
                        s.rem  = s.rem - {4'd0, ln};
                        s.slot = s.slot - 4'd1;
                    end else begin
                        s.done = 1'b1;
                    end
                end
            end
            n_st[g] = s;
        end
    end

    // Last stage: Lunar-to-Gregorian year rollover.
    always_comb begin
        t_work s;
        logic [8:0] ylen;
        s = r_st[NST-2];
        ylen = 9'd365;
        if (s.kind == KIND_L2G) begin
            s.pos  = s.pos + {4'd0, s.day};
            ylen   = greg_leap(s.year) ? 9'd366 : 9'd365;
            if (s.pos > ylen) begin
                s.year = s.year + 12'd1;
                s.pos  = s.pos - ylen;
            end
        end
        n_st[NST-1] = s;
    end

    // Pipeline registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < NST; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // Result formation: Gregorian month search or lunar month naming.
    t_rsp n_out;
    always_comb begin
        t_work      s;
        logic       lp;
        logic [3:0] lm;
        logic [3:0] om;
        s  = r_st[NST-1];
        n_out = '0;
        lp = greg_leap(s.year);
        lm = s.w[23:20];
        if (s.kind == KIND_L2G) begin
            om = 4'd12;
            for (int i = 12; i >= 1; i--) begin
                if (cum_days(4'(i), lp) >= s.pos) begin
                    om = 4'(i);
                end
            end
            n_out.out_year  = s.year;
            n_out.out_month = om;
            n_out.out_day   = 5'(s.pos - cum_days(om - 4'd1, lp));
        end else begin
            n_out.out_year = s.year;
            n_out.out_day  = s.back ? 5'(s.len - 5'(s.rem) + 5'd1) : 5'(s.rem + 9'd1);
            om = s.slot;
            if (lm != 4'd0) begin
                if (s.slot == lm + 4'd1) begin
                    om = lm;
                    n_out.out_leap = 1'b1;
                end else if (s.slot > lm + 4'd1) begin
                    om = s.slot - 4'd1;
                end
            end
            n_out.out_month = om;
        end
        if (s.bad) begin
            n_out = '0;
            n_out.status = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_vld[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    // A stalled result holds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_rsp.ready |=> r_out_vld && $stable(r_out))
        else $error("held result changed");
    // A good result has a month in range.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.status |-> r_out.out_month >= 4'd1 && r_out.out_month <= 4'd12)
        else $error("month out of range");
    // Stalls freeze the valid pipe.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("pipe moved under stall");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for lunar_solar_date_converter: directed and random dates,
// predicted in-bench and compared per field. Depends on lsdc_pkg, lsdc_if and the converter.
module tb_top
    import lsdc_pkg::*;
();

    localparam int unsigned TAB_FIRST = 1901;
    localparam int unsigned TAB_LAST  = 2099;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lsdc_if #(.T(t_req)) req_ch ();
    lsdc_if #(.T(t_rsp)) rsp_ch ();

    lunar_solar_date_converter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #4 i_clk = ~i_clk;

    logic [23:0] lunar_years [0:198] = '{
        24'h04AE53,24'h0A5748,24'h5526BD,24'h0D2650,24'h0D9544,24'h46AAB9,24'h056A4D,24'h09AD42,
        24'h24AEB6,24'h04AE4A,24'h6A4DBE,24'h0A4D52,24'h0D2546,24'h5D52BA,24'h0B544E,24'h0D6A43,
        24'h296D37,24'h095B4B,24'h749BC1,24'h049754,24'h0A4B48,24'h5B25BC,24'h06A550,24'h06D445,
        24'h4ADAB8,24'h02B64D,24'h095742,24'h2497B7,24'h04974A,24'h664B3E,24'h0D4A51,24'h0EA546,
        24'h56D4BA,24'h05AD4E,24'h02B644,24'h393738,24'h092E4B,24'h7C96BF,24'h0C9553,24'h0D4A48,
        24'h6DA53B,24'h0B554F,24'h056A45,24'h4AADB9,24'h025D4D,24'h092D42,24'h2C95B6,24'h0A954A,
        24'h7B4ABD,24'h06CA51,24'h0B5546,24'h555ABB,24'h04DA4E,24'h0A5B43,24'h352BB8,24'h052B4C,
        24'h8A953F,24'h0E9552,24'h06AA48,24'h6AD53C,24'h0AB54F,24'h04B645,24'h4A5739,24'h0A574D,
        24'h052642,24'h3E9335,24'h0D9549,24'h75AABE,24'h056A51,24'h096D46,24'h54AEBB,24'h04AD4F,
        24'h0A4D43,24'h4D26B7,24'h0D254B,24'h8D52BF,24'h0B5452,24'h0B6A47,24'h696D3C,24'h095B50,
        24'h049B45,24'h4A4BB9,24'h0A4B4D,24'hAB25C2,24'h06A554,24'h06D449,24'h6ADA3D,24'h0AB651,
        24'h093746,24'h5497BB,24'h04974F,24'h064B44,24'h36A537,24'h0EA54A,24'h86B2BF,24'h05AC53,
        24'h0AB647,24'h5936BC,24'h092E50,24'h0C9645,24'h4D4AB8,24'h0D4A4C,24'h0DA541,24'h25AAB6,
        24'h056A49,24'h7AADBD,24'h025D52,24'h092D47,24'h5C95BA,24'h0A954E,24'h0B4A43,24'h4B5537,
        24'h0AD54A,24'h955ABF,24'h04BA53,24'h0A5B48,24'h652BBC,24'h052B50,24'h0A9345,24'h474AB9,
        24'h06AA4C,24'h0AD541,24'h24DAB6,24'h04B64A,24'h69573D,24'h0A4E51,24'h0D2646,24'h5E933A,
        24'h0D534D,24'h05AA43,24'h36B537,24'h096D4B,24'hB4AEBF,24'h04AD53,24'h0A4D48,24'h6D25BC,
        24'h0D254F,24'h0D5244,24'h5DAA38,24'h0B5A4C,24'h056D41,24'h24ADB6,24'h049B4A,24'h7A4BBE,
        24'h0A4B51,24'h0AA546,24'h5B52BA,24'h06D24E,24'h0ADA42,24'h355B37,24'h09374B,24'h8497C1,
        24'h049753,24'h064B48,24'h66A53C,24'h0EA54F,24'h06B244,24'h4AB638,24'h0AAE4C,24'h092E42,
        24'h3C9735,24'h0C9649,24'h7D4ABD,24'h0D4A51,24'h0DA545,24'h55AABA,24'h056A4E,24'h0A6D43,
        24'h452EB7,24'h052D4B,24'h8A95BF,24'h0A9553,24'h0B4A47,24'h6B553B,24'h0AD54F,24'h055A45,
        24'h4A5D38,24'h0A5B4C,24'h052B42,24'h3A93B6,24'h069349,24'h7729BD,24'h06AA51,24'h0AD546,
        24'h54DABA,24'h04B64E,24'h0A5743,24'h452738,24'h0D264A,24'h8E933E,24'h0D5252,24'h0DAA47,
        24'h66B53B,24'h056D4F,24'h04AE45,24'h4A4EB9,24'h0A4D4C,24'h0D1541,24'h2D92B5};

    int unsigned days_before [0:12] = '{0,31,59,90,120,151,181,212,243,273,304,334,365};
    int unsigned days_in_mon [0:12] = '{0,31,28,31,30,31,30,31,31,30,31,30,31};

    t_req pending_reqs [$];
    t_rsp expected_dates [$];
    int   mismatch_cnt = 0;
    bit   stim_done = 1'b0;
    bit   no_idle = 1'b0;
    int   src_gap = 0;
    int   snk_gap = 0;

    function automatic bit is_leap_year(int unsigned y);
        return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    function automatic int unsigned moon_len(logic [23:0] w, int unsigned m);
        if (m < 1 || m > 13) return 29;
        return w[20 - m] ? 30 : 29;
    endfunction

    function automatic int unsigned new_year_doy(logic [23:0] w);
        return {27'd0, w[4:0]} - 1 + ((w[6:5] == 2'd2) ? 31 : 0);
    endfunction

    function automatic int unsigned before_month(int unsigned m, int unsigned y);
        return days_before[m] + ((is_leap_year(y) && m >= 2) ? 1 : 0);
    endfunction

    // Convert one date in either direction.
    function automatic t_rsp convert_date(t_req r);
        t_rsp        o;
        int unsigned y, m, d, lm, slot, pos, ylen, rem, lim, sp, doy, ln, i, oy, om;
        logic [23:0] w, pw;
        bit          ok;
        o  = '0;
        ok = 1'b0;
        y = {20'd0, r.year}; m = {28'd0, r.month}; d = {27'd0, r.day};
        slot = 0; ln = 0;
        if (y >= TAB_FIRST && y <= TAB_LAST && m >= 1 && m <= 12 && d >= 1) begin
            w  = lunar_years[y - TAB_FIRST];
            lm = {28'd0, w[23:20]};
            if (r.kind == KIND_L2G) begin
                slot = m;
                if (lm != 0 && (m > lm || (m == lm && r.leap_flag))) slot = m + 1;
                if (d <= moon_len(w, slot)) begin
                    pos = new_year_doy(w);
                    for (i = 1; i < slot; i++) pos += moon_len(w, i);
                    pos += d;
                    oy = y;
                    ylen = is_leap_year(y) ? 366 : 365;
                    // Past the end of the Gregorian year: roll into the next one.
                    if (pos > ylen) begin
                        oy = y + 1;
                        pos -= ylen;
                    end
                    om = 12;
                    for (i = 1; i <= 12; i++) begin
                        if (before_month(i, oy) >= pos) begin
                            om = i;
                            break;
                        end
                    end
                    o.out_year  = 12'(oy);
                    o.out_month = 4'(om);
                    o.out_day   = 5'(pos - before_month(om - 1, oy));
                end else begin
                    o.status = 1'b1;
                end
            end else begin
                lim = days_in_mon[m] + ((m == 2 && is_leap_year(y)) ? 1 : 0);
                if (d <= lim) begin
                    sp  = new_year_doy(w);
                    doy = before_month(m - 1, y) + d - 1;
                    if (doy >= sp) begin
                        rem  = doy - sp;
                        slot = 1;
                        for (i = 1; i <= 13; i++) begin
                            ln = moon_len(w, slot);
                            if (rem >= ln) begin
                                rem -= ln;
                                slot++;
                            end else break;
                        end
                        o.out_day  = 5'(rem + 1);
                        o.out_year = 12'(y);
                        ok = 1'b1;
                    end else if (y > TAB_FIRST) begin
                        // Before new year: walk back from the end of the previous lunar year.
                        pw   = lunar_years[y - 1 - TAB_FIRST];
                        rem  = sp - doy;
                        lm   = {28'd0, pw[23:20]};
                        slot = (lm != 0) ? 13 : 12;
                        ln   = moon_len(pw, slot);
                        for (i = slot; i > 10; i--) begin
                            ln = moon_len(pw, slot);
                            if (rem > ln) begin
                                rem -= ln;
                                slot--;
                            end else break;
                        end
                        o.out_day  = 5'(ln - rem + 1);
                        o.out_year = 12'(y - 1);
                        ok = 1'b1;
                    end
                    if (ok) begin
                        o.out_month = 4'(slot);
                        if (lm != 0) begin
                            if (slot == lm + 1) begin
                                o.out_month = 4'(lm);
                                o.out_leap  = 1'b1;
                            end else if (slot > lm + 1) begin
                                o.out_month = 4'(slot - 1);
                            end
                        end
                    end else begin
                        o = '0;
                        o.status = 1'b1;
                    end
                end else begin
                    o.status = 1'b1;
                end
            end
        end else begin
            o.status = 1'b1;
        end
        return o;
    endfunction

    function automatic t_req mk_req(logic k, int unsigned y, int unsigned m, int unsigned d,
                                    int unsigned lf);
        t_req r;
        r.kind = k; r.year = 12'(y); r.month = 4'(m); r.day = 5'(d); r.leap_flag = 1'(lf);
        return r;
    endfunction

    // Mostly valid dates in table range; some raw noise across all bits.
    function automatic t_req rand_req();
        t_req        r;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        r   = mk_req(1'($urandom_range(0, 1)), $urandom_range(TAB_FIRST, TAB_LAST),
                     $urandom_range(1, 12), $urandom_range(1, 30), $urandom_range(0, 1));
        if (sel < 10) begin
            r = t_req'(23'($urandom));
        end else if (sel < 20) begin
            r.day = 5'($urandom_range(0, 31));
            r.month = 4'($urandom_range(0, 15));
        end else if (sel < 35) begin
            // Dates around lunar new year, where the backward walk applies.
            r.kind  = KIND_G2L;
            r.month = 4'($urandom_range(1, 2));
            r.day   = 5'($urandom_range(1, 28));
        end else if (sel < 45) begin
            // Late lunar dates that roll into the next Gregorian year.
            r.kind  = KIND_L2G;
            r.month = 4'($urandom_range(11, 12));
        end
        return r;
    endfunction

    // Stimulus: directed cases, then random.
    initial begin
        pending_reqs.push_back(mk_req(KIND_G2L, 1901, 1, 1, 0));
        pending_reqs.push_back(mk_req(KIND_G2L, 1901, 2, 19, 0));
        pending_reqs.push_back(mk_req(KIND_G2L, 1902, 1, 1, 0));
        pending_reqs.push_back(mk_req(KIND_G2L, 2099, 12, 31, 1));
        pending_reqs.push_back(mk_req(KIND_G2L, 2000, 2, 29, 0));
        pending_reqs.push_back(mk_req(KIND_G2L, 1901, 2, 29, 0));
        pending_reqs.push_back(mk_req(KIND_G2L, 1900, 6, 1, 0));
        pending_reqs.push_back(mk_req(KIND_G2L, 2100, 1, 1, 0));
        pending_reqs.push_back(mk_req(KIND_G2L, 4095, 15, 31, 1));
        pending_reqs.push_back(mk_req(KIND_G2L, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(KIND_G2L, 1950, 4, 31, 0));
        pending_reqs.push_back(mk_req(KIND_G2L, 1950, 13, 1, 0));
        pending_reqs.push_back(mk_req(KIND_G2L, 1903, 6, 25, 0));
        pending_reqs.push_back(mk_req(KIND_L2G, 1901, 1, 1, 0));
        pending_reqs.push_back(mk_req(KIND_L2G, 2099, 12, 30, 0));
        pending_reqs.push_back(mk_req(KIND_L2G, 2099, 12, 29, 1));
        pending_reqs.push_back(mk_req(KIND_L2G, 1903, 5, 29, 1));
        pending_reqs.push_back(mk_req(KIND_L2G, 1903, 5, 29, 0));
        pending_reqs.push_back(mk_req(KIND_L2G, 1901, 4, 10, 1));
        pending_reqs.push_back(mk_req(KIND_L2G, 1984, 10, 30, 1));
        pending_reqs.push_back(mk_req(KIND_L2G, 2000, 1, 0, 0));
        pending_reqs.push_back(mk_req(KIND_L2G, 2000, 0, 5, 0));
        pending_reqs.push_back(mk_req(KIND_L2G, 1900, 1, 1, 0));
        pending_reqs.push_back(mk_req(KIND_L2G, 2050, 12, 31, 0));
        for (int i = 0; i < 1850; i++) pending_reqs.push_back(rand_req());
    end

    // Driver: presents queued requests with random idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
            src_gap      <= 0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid) expected_dates.push_back(convert_date(req_ch.data));
            if (src_gap > 0) begin
                req_ch.valid <= 1'b0;
                src_gap      <= src_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= pending_reqs.pop_front();
                if (pending_reqs.size() < 300) no_idle <= 1'b1;
                if (!no_idle && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 19);
            end else begin
                req_ch.valid <= 1'b0;
                stim_done    <= 1'b1;
            end
        end
    end

    // Result side: random back-pressure and per-field comparison.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            snk_gap      <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_dates.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) $display("Unexpected result %p", rsp_ch.data);
                end else begin
                    t_rsp e;
                    e = expected_dates.pop_front();
                    if (e.status !== rsp_ch.data.status || e.out_year !== rsp_ch.data.out_year
                        || e.out_month !== rsp_ch.data.out_month
                        || e.out_day !== rsp_ch.data.out_day
                        || e.out_leap !== rsp_ch.data.out_leap) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("Mismatch: expected %p, got %p", e, rsp_ch.data);
                    end
                end
            end
            if (snk_gap > 0) begin
                rsp_ch.ready <= 1'b0;
                snk_gap      <= snk_gap - 1;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                rsp_ch.ready <= 1'b0;
                snk_gap      <= $urandom_range(0, 18);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Reset, then wait for drain and settle.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && expected_dates.size() == 0);
        repeat (40) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_dates.size() == 0) begin
            $display("lunar_solar_date_converter verification clean");
        end else begin
            $display("lunar_solar_date_converter verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("lunar_solar_date_converter verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/lsdc_pkg.sv
sv/lsdc_if.sv
sv/lunar_solar_date_converter.sv
tb/tb_top.sv
